// ----- rtl/mrf_pkg.sv -----
// Shared types, constants and the CRC-16/MODBUS byte update for the read request framer.
// No dependencies.
package mrf_pkg;

	localparam logic [7:0]  FuncReadHolding = 8'h03;
	localparam logic [15:0] CrcInit         = 16'hFFFF;
	localparam logic [15:0] CrcPolyRefl     = 16'hA001;

	localparam int          FrameLen = 8;
	localparam int          IdxW     = $clog2(FrameLen);

	localparam logic [IdxW-1:0] IdxAddr    = 3'd0;
	localparam logic [IdxW-1:0] IdxFunc    = 3'd1;
	localparam logic [IdxW-1:0] IdxStartHi = 3'd2;
	localparam logic [IdxW-1:0] IdxStartLo = 3'd3;
	localparam logic [IdxW-1:0] IdxCountHi = 3'd4;
	localparam logic [IdxW-1:0] IdxCountLo = 3'd5;
	localparam logic [IdxW-1:0] IdxCrcLo   = 3'd6;
	localparam logic [IdxW-1:0] IdxCrcHi   = 3'd7;

	typedef struct packed {
		logic [7:0]  dev_address;
		logic [15:0] start_register;
		logic [15:0] register_count;
	} req_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPolyRefl;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/mrf_req_fifo.sv -----
// Two-entry request queue between the accepting front and the frame serializer.
// Depends on mrf_pkg.
module mrf_req_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mrf_pkg::req_t wr_req,
	output logic          full,
	input  logic          pop_en,
	output logic          rd_valid,
	output mrf_pkg::req_t rd_req
);
	import mrf_pkg::*;

	req_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_req   = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_req;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("request queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("request queue pointers disagree with count");

endmodule

// ----- rtl/mrf_serializer.sv -----
// Back end: walks one request through its eight frame bytes, folding the CRC as it goes,
// and holds the current beat in the output register. Depends on mrf_pkg.
module mrf_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  mrf_pkg::req_t req,
	output logic          req_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    frame_byte,
	output logic          last_byte
);
	import mrf_pkg::*;

	logic [IdxW-1:0] idx_q;
	logic [15:0]     crc_q;
	logic            out_valid_q;
	logic [7:0]      byte_q;
	logic            last_q;
	logic            adv;
	logic            fire;
	logic [7:0]      cur_byte;
	logic [15:0]     crc_base;
	logic [15:0]     crc_nx;

	assign adv  = !out_valid_q || pop;
	assign fire = adv && req_valid;
	assign req_pop = fire && (idx_q == IdxCrcHi);

	always_comb begin
		unique case (idx_q)
			IdxAddr:    cur_byte = req.dev_address;
			IdxFunc:    cur_byte = FuncReadHolding;
			IdxStartHi: cur_byte = req.start_register[15:8];
			IdxStartLo: cur_byte = req.start_register[7:0];
			IdxCountHi: cur_byte = req.register_count[15:8];
			IdxCountLo: cur_byte = req.register_count[7:0];
			IdxCrcLo:   cur_byte = crc_q[7:0];
			IdxCrcHi:   cur_byte = crc_q[15:8];
			default:    cur_byte = 8'h00;
		endcase
	end

	assign crc_base = (idx_q == IdxAddr) ? CrcInit : crc_q;
	assign crc_nx   = crc16_byte(crc_base, cur_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= IdxAddr;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				idx_q       <= idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= cur_byte;
			last_q <= (idx_q == IdxCrcHi);
			if (idx_q < IdxCrcLo) crc_q <= crc_nx;
		end
	end

	assign empty      = !out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!req_valid |-> idx_q == IdxAddr)
		else $error("byte index left mid-frame without a request");
	a_func_code: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && idx_q == IdxFunc) |=> (byte_q == FuncReadHolding && !last_q))
		else $error("function code beat wrong");
	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |=> (out_valid_q && last_q && idx_q == IdxAddr))
		else $error("request released without last beat");

endmodule

// ----- rtl/modbus_read_request_framer_unit.sv -----
// Modbus RTU read-holding-registers request framer: eight beats per request,
// CRC-16/MODBUS appended low byte first. Depends on mrf_pkg, mrf_req_fifo, mrf_serializer.
// The first beat of a frame passes through the request queue and then the output register; a held beat stalls it.
// Throughput: one beat per cycle while the consumer pops, set by the single output byte lane.
// A two-entry request queue lets requests be taken while a frame is still going out.
// Reset (arst_n low): queue and serializer cleared, no beats pending.
module modbus_read_request_framer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  dev_address,
	input  logic [15:0] start_register,
	input  logic [15:0] register_count,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);
	import mrf_pkg::*;

	req_t wr_req;
	req_t rd_req;
	logic rd_valid;
	logic req_pop;

	assign wr_req.dev_address    = dev_address;
	assign wr_req.start_register = start_register;
	assign wr_req.register_count = register_count;

	mrf_req_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_req   (wr_req),
		.full     (full),
		.pop_en   (req_pop),
		.rd_valid (rd_valid),
		.rd_req   (rd_req)
	);

	mrf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (rd_valid),
		.req        (rd_req),
		.req_pop    (req_pop),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule
